// ===== sv/tcis_pkg.sv =====
// ----------------------------------------------------------------------------
// tcis_pkg: shared types and constants
// Table depth, field widths, controller state encoding and the command and
// status bundles between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package tcis_pkg;

    localparam int MAX_ANGLES = 256;
    localparam int IDX_W      = $clog2(MAX_ANGLES);
    localparam int CNT_W      = $clog2(MAX_ANGLES + 1);
    localparam int CDF_W      = 41;
    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 32;
    localparam int DIV_CNT_W  = $clog2(FRAC_W);
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 40;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef enum logic [11:0] {
        ST_IDLE      = 12'b0000_0000_0001,
        ST_TGT_LO    = 12'b0000_0000_0010,
        ST_TGT_HI    = 12'b0000_0000_0100,
        ST_TGT_SUM   = 12'b0000_0000_1000,
        ST_SRCH_RD   = 12'b0000_0001_0000,
        ST_SRCH_CMP  = 12'b0000_0010_0000,
        ST_FETCH_LO  = 12'b0000_0100_0000,
        ST_FETCH_HI  = 12'b0000_1000_0000,
        ST_FETCH_END = 12'b0001_0000_0000,
        ST_DIVIDE    = 12'b0010_0000_0000,
        ST_MULT      = 12'b0100_0000_0000,
        ST_FINISH    = 12'b1000_0000_0000
    } tcis_state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic tgt_lo;
        logic tgt_hi;
        logic tgt_sum;
        logic srch_rd;
        logic srch_cmp;
        logic fetch_lo;
        logic fetch_hi;
        logic fetch_end;
        logic div_step;
        logic mult;
        logic finish;
    } tcis_cmd_t;

    typedef struct packed {
        logic bad;
        logic srch_done;
        logic at_last;
        logic div_last;
        logic out_free;
    } tcis_stat_t;

endpackage

// ===== sv/tcis_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcis_ctrl: sample sequencer
// One-hot state machine that steps the datapath through target scaling,
// binary search, interval fetch, fraction division and interpolation.
// ----------------------------------------------------------------------------
module tcis_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  logic               in_req,
    output logic               in_ready,
    input  tcis_pkg::tcis_stat_t stat,
    output tcis_pkg::tcis_cmd_t  cmd
);
    import tcis_pkg::*;

    tcis_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_req == REQ_LOAD) begin
                        cmd.load = 1'b1;
                    end else begin
                        cmd.start  = 1'b1;
                        state_next = stat.bad ? ST_FINISH : ST_TGT_LO;
                    end
                end
            end
            ST_TGT_LO: begin
                cmd.tgt_lo = 1'b1;
                state_next = ST_TGT_HI;
            end
            ST_TGT_HI: begin
                cmd.tgt_hi = 1'b1;
                state_next = ST_TGT_SUM;
            end
            ST_TGT_SUM: begin
                cmd.tgt_sum = 1'b1;
                state_next  = ST_SRCH_RD;
            end
            ST_SRCH_RD: begin
                if (stat.srch_done) begin
                    state_next = ST_FETCH_LO;
                end else begin
                    cmd.srch_rd = 1'b1;
                    state_next  = ST_SRCH_CMP;
                end
            end
            ST_SRCH_CMP: begin
                cmd.srch_cmp = 1'b1;
                state_next   = ST_SRCH_RD;
            end
            ST_FETCH_LO: begin
                cmd.fetch_lo = 1'b1;
                state_next   = ST_FETCH_HI;
            end
            ST_FETCH_HI: begin
                cmd.fetch_hi = 1'b1;
                state_next   = ST_FETCH_END;
            end
            ST_FETCH_END: begin
                cmd.fetch_end = 1'b1;
                state_next    = stat.at_last ? ST_FINISH : ST_DIVIDE;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT: begin
                cmd.mult   = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/tcis_dpath.sv =====
// ----------------------------------------------------------------------------
// tcis_dpath: table storage and arithmetic
// CDF and cosine memories, target scaling on a shared multiplier, search
// bounds, restoring divider and the output beat register.
// ----------------------------------------------------------------------------
module tcis_dpath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  tcis_pkg::tcis_cmd_t              cmd,
    output tcis_pkg::tcis_stat_t             stat,
    input  logic [tcis_pkg::IN_TDATA_W-1:0]  in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [tcis_pkg::OUT_TDATA_W-1:0] out_data,
    output logic                             out_status
);
    import tcis_pkg::*;

    logic [IDX_W-1:0]  in_idx;
    logic [DATA_W-1:0] in_phase;
    logic [DATA_W-1:0] in_cos;
    logic [FRAC_W-1:0] in_rand;

    assign in_idx   = in_data[7:0];
    assign in_phase = in_data[39:8];
    assign in_cos   = in_data[71:40];
    assign in_rand  = in_data[103:72];

    // table state
    logic [CDF_W-1:0]  cdf_mem [MAX_ANGLES];
    logic [DATA_W-1:0] cos_mem [MAX_ANGLES];
    logic [CNT_W-1:0]  entries_reg;
    logic [DATA_W-1:0] prev_phase_reg;
    logic [CDF_W-1:0]  last_cdf_reg;
    logic [CDF_W-1:0]  load_cdf;
    logic              load_first;
    logic              load_next;
    logic              load_we;
    logic [CDF_W-1:0]  wr_cdf;

    assign load_cdf   = last_cdf_reg + CDF_W'(prev_phase_reg) + CDF_W'(in_phase);
    assign load_first = cmd.load && (in_idx == '0);
    assign load_next  = cmd.load && (CNT_W'(in_idx) == entries_reg);
    assign load_we    = load_first || load_next;
    assign wr_cdf     = load_first ? '0 : load_cdf;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_reg    <= '0;
            prev_phase_reg <= '0;
            last_cdf_reg   <= '0;
        end else if (load_we) begin
            entries_reg    <= CNT_W'(in_idx) + CNT_W'(1);
            prev_phase_reg <= in_phase;
            last_cdf_reg   <= wr_cdf;
        end
    end

    // sample working registers
    logic [FRAC_W-1:0]  rand_reg;
    logic               fail_reg;
    logic [CDF_W-1:0]   target_reg;
    logic [IDX_W-1:0]   lo_reg;
    logic [IDX_W-1:0]   hi_reg;
    logic [IDX_W-1:0]   mid_reg;
    logic [IDX_W-1:0]   mid_c;
    logic [IDX_W:0]     mid_sum;
    logic [IDX_W-1:0]   last_idx;
    logic [IDX_W-1:0]   rd_addr;
    logic [CDF_W-1:0]   cdf_rd_reg;
    logic [DATA_W-1:0]  cos_rd_reg;
    logic [CDF_W-1:0]   cdf_lo_reg;
    logic [DATA_W-1:0]  cos_lo_reg;
    logic [DATA_W-1:0]  cos_hi_reg;
    logic [CDF_W-1:0]   den_reg;
    logic [CDF_W:0]     rem_reg;
    logic [CDF_W:0]     rem_sh;
    logic [FRAC_W-1:0]  w_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic               d_neg_reg;
    logic [DATA_W:0]    mag_reg;
    logic [DATA_W:0]    diff;
    logic [DATA_W:0]    mul_a;
    logic [FRAC_W-1:0]  mul_b;
    logic [DATA_W+FRAC_W:0] prod_reg;
    logic [DATA_W-1:0]  step;
    logic [DATA_W-1:0]  interp;

    assign mid_sum  = (IDX_W+1)'(lo_reg) + (IDX_W+1)'(hi_reg) + (IDX_W+1)'(1);
    assign mid_c    = mid_sum[IDX_W:1];
    assign last_idx = IDX_W'(entries_reg - CNT_W'(1));

    always_comb begin
        priority if (cmd.srch_rd) begin
            rd_addr = mid_c;
        end else if (cmd.fetch_hi) begin
            rd_addr = lo_reg + IDX_W'(1);
        end else begin
            rd_addr = lo_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_we) begin
            cdf_mem[in_idx] <= wr_cdf;
            cos_mem[in_idx] <= in_cos;
        end
        cdf_rd_reg <= cdf_mem[rd_addr];
        cos_rd_reg <= cos_mem[rd_addr];
    end

    // shared multiplier: target scaling and interpolation step
    always_comb begin
        priority if (cmd.tgt_lo) begin
            mul_a = {1'b0, last_cdf_reg[31:0]};
            mul_b = rand_reg;
        end else if (cmd.tgt_hi) begin
            mul_a = (DATA_W+1)'(last_cdf_reg[CDF_W-1:32]);
            mul_b = rand_reg;
        end else begin
            mul_a = mag_reg;
            mul_b = w_reg;
        end
    end

    assign rem_sh = {rem_reg[CDF_W-1:0], 1'b0};
    assign diff   = {cos_hi_reg[DATA_W-1], cos_hi_reg} - {cos_lo_reg[DATA_W-1], cos_lo_reg};
    assign step   = prod_reg[DATA_W+FRAC_W-1:FRAC_W];
    assign interp = d_neg_reg ? (cos_lo_reg - step) : (cos_lo_reg + step);

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            rand_reg <= in_rand;
            fail_reg <= stat.bad;
            lo_reg   <= '0;
            hi_reg   <= last_idx;
        end
        if (cmd.tgt_lo || cmd.tgt_hi || cmd.mult) begin
            prod_reg <= (DATA_W+FRAC_W+1)'(mul_a) * (DATA_W+FRAC_W+1)'(mul_b);
        end
        if (cmd.tgt_hi) begin
            target_reg <= CDF_W'(prod_reg[DATA_W+FRAC_W-1:FRAC_W]);
        end
        if (cmd.tgt_sum) begin
            target_reg <= target_reg + prod_reg[CDF_W-1:0];
        end
        if (cmd.srch_rd) begin
            mid_reg <= mid_c;
        end
        if (cmd.srch_cmp) begin
            if (cdf_rd_reg <= target_reg) begin
                lo_reg <= mid_reg;
            end else begin
                hi_reg <= mid_reg - IDX_W'(1);
            end
        end
        if (cmd.fetch_hi) begin
            cdf_lo_reg <= cdf_rd_reg;
            cos_lo_reg <= cos_rd_reg;
        end
        if (cmd.fetch_end) begin
            cos_hi_reg  <= cos_rd_reg;
            den_reg     <= cdf_rd_reg - cdf_lo_reg;
            rem_reg     <= {1'b0, target_reg - cdf_lo_reg};
            w_reg       <= '0;
            div_cnt_reg <= '0;
        end
        if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            d_neg_reg   <= diff[DATA_W];
            mag_reg     <= diff[DATA_W] ? -diff : diff;
            if (rem_sh >= {1'b0, den_reg}) begin
                rem_reg <= rem_sh - {1'b0, den_reg};
                w_reg   <= {w_reg[FRAC_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                w_reg   <= {w_reg[FRAC_W-2:0], 1'b0};
            end
        end
    end

    // output beat register
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_status_reg;
    logic [DATA_W-1:0]      res_cos;

    always_comb begin
        priority if (fail_reg) begin
            res_cos = '0;
        end else if (lo_reg == last_idx) begin
            res_cos = cos_lo_reg;
        end else begin
            res_cos = interp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_data_reg   <= {fail_reg ? '0 : lo_reg, res_cos};
            out_status_reg <= fail_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign out_status = out_status_reg;

    assign stat.bad       = (entries_reg < CNT_W'(2)) || (last_cdf_reg == '0);
    assign stat.srch_done = (lo_reg == hi_reg);
    assign stat.at_last   = (lo_reg == last_idx);
    assign stat.div_last  = (div_cnt_reg == DIV_CNT_W'(FRAC_W - 1));
    assign stat.out_free  = !out_valid_reg || out_ready;

endmodule

// ===== sv/tabulated_cdf_inverse_sampler.sv =====
// ----------------------------------------------------------------------------
// tabulated_cdf_inverse_sampler: inverse-transform sampler over a tabulated CDF
// Loads a phase/cosine table, builds a doubled trapezoidal CDF and draws
// interpolated cosine samples from 32-bit random fractions.
// ----------------------------------------------------------------------------
// usage
//   s_axis: one beat per request; tuser selects load (0) or sample (1).
//   loads must come in index order, index 0 restarts the table; a load with
//   any other index than the current entry count is dropped
//   m_axis: one beat per sample, none per load; tuser carries the status
//   flag (1 = fewer than two entries or zero total, data then zero)
// sample sequence
//   loads are accepted back to back while idle
//   a sample runs target scaling, the search steps (1 to 8), a check that sees
//   the end of the search, the interval fetch, the bit-serial divider, the
//   interpolation multiply and the output register; divider and multiply are
//   skipped when the low index is the last entry; the next beat can be taken
//   once the result is valid; a failing sample goes straight to the output register
// reset
//   clears entry count, last phase, CDF total and output valid; table contents
//   stay undefined and are only used below the entry count
// stalls
//   a finished result waits in the output register; further loads are taken
//   meanwhile, a following sample completes and then waits for m_axis_tready
// ----------------------------------------------------------------------------
module tabulated_cdf_inverse_sampler (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // entry_index, phase_value, cos_value, random_fraction
    input  logic [tcis_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // req_type
    input  logic [0:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // cos_angle, low_index
    output logic [tcis_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // status
    output logic [0:0]                        m_axis_tuser
);
    import tcis_pkg::*;

    tcis_cmd_t  cmd;
    tcis_stat_t stat;

    tcis_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_req   (s_axis_tuser[0]),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tcis_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_data    (s_axis_tdata),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_status (m_axis_tuser[0])
    );

endmodule
